FILE: rtl/vtg_pkg.sv
package vtg_pkg;

	localparam int DOT_W      = 9;
	localparam int LINE_W     = 8;
	localparam int IRQ_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_MATCH_TARGET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_IRQ_ENABLE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_IRQ_ENABLE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_MATCH_IRQ_ENABLE = 2'd3;

	// interrupt request bit positions
	localparam int IRQ_VBLANK = 0;
	localparam int IRQ_HBLANK = 1;
	localparam int IRQ_MATCH  = 2;

	typedef struct packed {
		logic [LINE_W-1:0] line_match_target;
		logic              hblank_irq_enable;
		logic              vblank_irq_enable;
		logic              line_match_irq_enable;
	} cfg_t;

	typedef struct packed {
		logic [DOT_W-1:0]  dot_position;
		logic [LINE_W-1:0] line_number;
		logic              in_hblank;
		logic              in_vblank;
		logic              line_match;
		logic [IRQ_W-1:0]  irq_request;
		logic              frame_done;
	} res_t;

endpackage

FILE: rtl/vtg_if.sv
interface vtg_tick_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink   (input valid, input advance, output ready);
endinterface

interface vtg_res_if import vtg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DOT_W-1:0]  dot_position;
	logic [LINE_W-1:0] line_number;
	logic              in_hblank;
	logic              in_vblank;
	logic              line_match;
	logic [IRQ_W-1:0]  irq_request;
	logic              frame_done;

	modport source (output valid, output dot_position, output line_number, output in_hblank,
		output in_vblank, output line_match, output irq_request, output frame_done,
		input ready);
	modport sink   (input valid, input dot_position, input line_number, input in_hblank,
		input in_vblank, input line_match, input irq_request, input frame_done,
		output ready);
endinterface

FILE: rtl/vtg_core.sv
module vtg_core import vtg_pkg::*; #(
	parameter int VISIBLE_DOTS    = 240,
	parameter int DOTS_PER_LINE   = 308,
	parameter int VISIBLE_LINES   = 160,
	parameter int LINES_PER_FRAME = 228
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic advance,
	input  cfg_t cfg,
	output res_t nxt
);

	localparam logic [DOT_W-1:0]  HB_DOT    = DOT_W'(VISIBLE_DOTS);
	localparam logic [DOT_W-1:0]  LINE_DOTS = DOT_W'(DOTS_PER_LINE);
	localparam logic [LINE_W-1:0] VB_LINE   = LINE_W'(VISIBLE_LINES);
	localparam logic [LINE_W-1:0] FR_LINES  = LINE_W'(LINES_PER_FRAME);
	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_FRAME - 1);

	logic [DOT_W-1:0]  dot_q;
	logic [LINE_W-1:0] line_q;
	logic              hblank_q;
	logic              vblank_q;
	logic              match_q;

	logic [DOT_W-1:0]  dot_inc;
	logic [LINE_W-1:0] line_inc;

	assign dot_inc  = dot_q + DOT_W'(1);
	assign line_inc = line_q + LINE_W'(1);

	always_comb begin
		nxt              = '0;
		nxt.dot_position = dot_q;
		nxt.line_number  = line_q;
		nxt.in_hblank    = hblank_q;
		nxt.in_vblank    = vblank_q;
		nxt.line_match   = match_q;
		if (advance) begin
			nxt.dot_position = dot_inc;
			if (dot_inc == HB_DOT) begin
				nxt.in_hblank              = 1'b1;
				nxt.irq_request[IRQ_HBLANK] = cfg.hblank_irq_enable;
			end else if (dot_inc >= LINE_DOTS) begin
				nxt.dot_position = '0;
				nxt.line_number  = (line_inc >= FR_LINES) ? '0 : line_inc;
				nxt.line_match   = (nxt.line_number == cfg.line_match_target);
				nxt.irq_request[IRQ_MATCH] = nxt.line_match & cfg.line_match_irq_enable;
				nxt.in_hblank    = 1'b0;
				if (nxt.line_number == VB_LINE) begin
					nxt.in_vblank               = 1'b1;
					nxt.irq_request[IRQ_VBLANK] = cfg.vblank_irq_enable;
				end
				// last line: blank ends and the frame is handed off
				if (nxt.line_number == LAST_LINE) begin
					nxt.in_vblank  = 1'b0;
					nxt.frame_done = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			line_q   <= '0;
			hblank_q <= 1'b0;
			vblank_q <= 1'b0;
			match_q  <= 1'b0;
		end else if (step) begin
			dot_q    <= nxt.dot_position;
			line_q   <= nxt.line_number;
			hblank_q <= nxt.in_hblank;
			vblank_q <= nxt.in_vblank;
			match_q  <= nxt.line_match;
		end
	end

endmodule

FILE: rtl/video_timing_generator.sv
// Dot-clock raster timing generator (hsync/vsync style counters for an LCD).
//
// Channels:
//   tick : one beat per dot-clock tick, payload advance (1 steps a dot,
//          0 holds every counter and flag).
//   res  : one beat per tick with dot/line position, blank flags, the
//          line-match flag, one-beat irq_request pulses (bit0 vblank,
//          bit1 hblank, bit2 line match) and the frame_done pulse.
//   cfg  : write-only register port (cfg_write, cfg_index, cfg_data);
//          index 0 target line, 1 hblank irq enable, 2 vblank irq enable,
//          3 line-match irq enable. Write only while the block is idle.
// Result: the result beat is registered and shows in the cycle after its tick is taken.
// Throughput: one tick per cycle unless the receiver stalls; the counter update
//   is a single add and compare ahead of the result register.
// Stall: tick.ready = !res.valid || res.ready, so a stalled receiver holds
//   the result register and ticks back up at the source; nothing is lost.
// Reset: counters, flags, enables and target clear; no result is pending.
module video_timing_generator import vtg_pkg::*; #(
	parameter int VISIBLE_DOTS    = 240,
	parameter int DOTS_PER_LINE   = 308,
	parameter int VISIBLE_LINES   = 160,
	parameter int LINES_PER_FRAME = 228
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vtg_tick_if.sink              tick,
	vtg_res_if.source             res
);

	cfg_t cfg_q;
	res_t nxt;
	res_t res_q;
	logic res_valid_q;
	logic take;

	// register file; enables keep only bit 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LINE_MATCH_TARGET:     cfg_q.line_match_target     <= cfg_data[LINE_W-1:0];
				CFG_HBLANK_IRQ_ENABLE:     cfg_q.hblank_irq_enable     <= cfg_data[0];
				CFG_VBLANK_IRQ_ENABLE:     cfg_q.vblank_irq_enable     <= cfg_data[0];
				CFG_LINE_MATCH_IRQ_ENABLE: cfg_q.line_match_irq_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a tick is taken whenever the result slot is free or draining
	assign tick.ready = !res_valid_q || res.ready;
	assign take       = tick.valid && tick.ready;

	vtg_core #(
		.VISIBLE_DOTS   (VISIBLE_DOTS),
		.DOTS_PER_LINE  (DOTS_PER_LINE),
		.VISIBLE_LINES  (VISIBLE_LINES),
		.LINES_PER_FRAME(LINES_PER_FRAME)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.advance(tick.advance),
		.cfg    (cfg_q),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= nxt;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.dot_position = res_q.dot_position;
	assign res.line_number  = res_q.line_number;
	assign res.in_hblank    = res_q.in_hblank;
	assign res.in_vblank    = res_q.in_vblank;
	assign res.line_match   = res_q.line_match;
	assign res.irq_request  = res_q.irq_request;
	assign res.frame_done   = res_q.frame_done;

endmodule

FILE: rtl/vtg_checker.sv
module vtg_checker import vtg_pkg::*; #(
	parameter int VISIBLE_DOTS    = 240,
	parameter int DOTS_PER_LINE   = 308,
	parameter int VISIBLE_LINES   = 160,
	parameter int LINES_PER_FRAME = 228
) (
	input logic              clk,
	input logic              arst_n,
	input logic              tick_valid,
	input logic              tick_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [DOT_W-1:0]  dot_position,
	input logic [LINE_W-1:0] line_number,
	input logic              in_hblank,
	input logic              in_vblank,
	input logic              line_match,
	input logic [IRQ_W-1:0]  irq_request,
	input logic              frame_done
);

	localparam logic [DOT_W-1:0]  HB_DOT    = DOT_W'(VISIBLE_DOTS);
	localparam logic [DOT_W-1:0]  LINE_DOTS = DOT_W'(DOTS_PER_LINE);
	localparam logic [LINE_W-1:0] VB_LINE   = LINE_W'(VISIBLE_LINES);
	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_FRAME - 1);
	localparam bit                DOT_SANE  = VISIBLE_DOTS < DOTS_PER_LINE;

	// stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(dot_position)
			&& $stable(line_number) && $stable(irq_request) && $stable(frame_done))
		else $error("result changed while stalled");

	// a taken tick always yields a beat next cycle, and ticks are only taken
	// when the result slot can move
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |-> (!res_valid || res_ready) ##1 res_valid)
		else $error("tick taken without a result slot");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> dot_position == '0 && line_number == LAST_LINE
			&& !in_vblank)
		else $error("frame_done away from last line start");

	a_irq_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!irq_request[IRQ_HBLANK] || (in_hblank && dot_position == HB_DOT))
			&& (!irq_request[IRQ_MATCH] || (line_match && dot_position == '0))
			&& (!irq_request[IRQ_VBLANK] || (line_number == VB_LINE && dot_position == '0)))
		else $error("irq pulse at wrong position");

	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && DOT_SANE |-> dot_position < LINE_DOTS)
		else $error("dot position beyond line length");

endmodule

bind video_timing_generator vtg_checker #(
	.VISIBLE_DOTS   (VISIBLE_DOTS),
	.DOTS_PER_LINE  (DOTS_PER_LINE),
	.VISIBLE_LINES  (VISIBLE_LINES),
	.LINES_PER_FRAME(LINES_PER_FRAME)
) u_vtg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_valid  (tick.valid),
	.tick_ready  (tick.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.dot_position(res.dot_position),
	.line_number (res.line_number),
	.in_hblank   (res.in_hblank),
	.in_vblank   (res.in_vblank),
	.line_match  (res.line_match),
	.irq_request (res.irq_request),
	.frame_done  (res.frame_done)
);

FILE: dv/tb_video_timing_generator.sv
`timescale 1ns / 100ps

module tb_video_timing_generator;
	import vtg_pkg::*;

	// raster geometry, passed to the block and used by the predictor
	localparam int H_ACTIVE = 240;
	localparam int H_TOTAL  = 308;
	localparam int V_ACTIVE = 160;
	localparam int V_TOTAL  = 228;

	// irq_request patterns built from the package bit positions
	localparam logic [IRQ_W-1:0] IRQ_NONE = '0;
	localparam logic [IRQ_W-1:0] IRQ_HB   = IRQ_W'(1 << IRQ_HBLANK);
	localparam logic [IRQ_W-1:0] IRQ_LM   = IRQ_W'(1 << IRQ_MATCH);

	localparam int CHUNK_TICKS     = 55;    // random ticks per register setting
	localparam int PRESSURE_CYCLES = 300;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT  = 5000;  // quiet cycles before giving up

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vtg_tick_if tick_ch ();
	vtg_res_if  res_ch ();

	video_timing_generator #(
		.VISIBLE_DOTS    (H_ACTIVE),
		.DOTS_PER_LINE   (H_TOTAL),
		.VISIBLE_LINES   (V_ACTIVE),
		.LINES_PER_FRAME (V_TOTAL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.res       (res_ch)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Raster predictor: own copy of counters, flags and register values.
	// ------------------------------------------------------------------
	logic [DOT_W-1:0]  dot_q;
	logic [LINE_W-1:0] line_q;
	logic              hblank_q, vblank_q, match_q;
	logic [LINE_W-1:0] target_q;
	logic              hb_irq_en, vb_irq_en, lm_irq_en;

	// Advance the raster by one tick and return the beat it should produce.
	function automatic res_t raster_step(input logic adv);
		res_t             r;
		logic [IRQ_W-1:0] irq;
		logic             done;
		irq  = IRQ_NONE;
		done = 1'b0;
		if (adv) begin
			dot_q = dot_q + 1'b1;
			if (dot_q == H_ACTIVE) begin
				hblank_q = 1'b1;
				if (hb_irq_en) irq[IRQ_HBLANK] = 1'b1;
			end else if (dot_q >= H_TOTAL) begin
				// end of line: wrap dot, step line, then compare (line 0 can match)
				dot_q  = '0;
				line_q = line_q + 1'b1;
				if (line_q >= V_TOTAL) line_q = '0;
				match_q = (line_q == target_q);
				if (match_q && lm_irq_en) irq[IRQ_MATCH] = 1'b1;
				hblank_q = 1'b0;
				if (line_q == V_ACTIVE) begin
					vblank_q = 1'b1;
					if (vb_irq_en) irq[IRQ_VBLANK] = 1'b1;
				end
				// vblank drop wins if both lines coincide; irq pulse above stays
				if (line_q == V_TOTAL - 1) begin
					vblank_q = 1'b0;
					done     = 1'b1;
				end
			end
		end
		r.dot_position = dot_q;
		r.line_number  = line_q;
		r.in_hblank    = hblank_q;
		r.in_vblank    = vblank_q;
		r.line_match   = match_q;
		r.irq_request  = irq;
		r.frame_done   = done;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard state and run statistics
	// ------------------------------------------------------------------
	res_t pending_beats [$];
	int   mismatches   = 0;
	int   beats_seen   = 0;
	int   hold_ticks   = 0;
	int   frames_seen  = 0;
	int   match_pulses = 0;
	int   hb_pulses    = 0;
	int   vb_pulses    = 0;
	int   reg_writes   = 0;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_req      = 1'b0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;

	// ------------------------------------------------------------------
	// Directed plan. Each row is a run of identical ticks; where pinned is
	// set, the last beat of the run is checked against the typed-in value,
	// everything else against the predictor.
	// Runs with target line 1 and all irq enables on.
	// ------------------------------------------------------------------
	typedef struct {
		logic        adv;
		int unsigned reps;
		logic        pinned;
		res_t        want;
	} plan_row_t;

	plan_row_t plan [10] = '{
		// hold right after reset: everything still zero
		'{1'b0, 1,     1'b1, {9'd0,   8'd0,   1'b0, 1'b0, 1'b0, IRQ_NONE, 1'b0}},
		'{1'b1, 1,     1'b1, {9'd1,   8'd0,   1'b0, 1'b0, 1'b0, IRQ_NONE, 1'b0}},
		'{1'b0, 3,     1'b0, '0},
		'{1'b1, 238,   1'b0, '0},
		// hblank rises with its pulse, then a hold drops the pulse
		'{1'b1, 1,     1'b1, {9'd240, 8'd0,   1'b1, 1'b0, 1'b0, IRQ_HB,   1'b0}},
		'{1'b0, 1,     1'b1, {9'd240, 8'd0,   1'b1, 1'b0, 1'b0, IRQ_NONE, 1'b0}},
		'{1'b1, 66,    1'b0, '0},
		'{1'b1, 1,     1'b1, {9'd307, 8'd0,   1'b1, 1'b0, 1'b0, IRQ_NONE, 1'b0}},
		// line wrap into the target line
		'{1'b1, 1,     1'b1, {9'd0,   8'd1,   1'b0, 1'b0, 1'b1, IRQ_LM,   1'b0}},
		'{1'b1, 308,   1'b1, {9'd0,   8'd2,   1'b0, 1'b0, 1'b0, IRQ_NONE, 1'b0}}
	};

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one tick beat; returns at the edge it is taken and queues the
	// expected result beat.
	task automatic send_tick(input logic adv, input logic pinned, input res_t pinned_val);
		res_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid   <= 1'b1;
		tick_ch.advance <= adv;
		do @(posedge clk); while (!tick_ch.ready);
		want = raster_step(adv);
		if (pinned) want = pinned_val;
		pending_beats.push_back(want);
		if (!adv) hold_ticks++;
	endtask

	// Stop offering, wait for every result beat, then let the result register empty.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write all four registers back to back; raw bytes so upper bits of the
	// one-bit enables get exercised and must be dropped.
	task automatic program_regs(input logic [7:0] tgt, input logic [7:0] hen,
		input logic [7:0] ven, input logic [7:0] men);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [7:0]           val [4];
		idx = '{CFG_LINE_MATCH_TARGET, CFG_HBLANK_IRQ_ENABLE,
			CFG_VBLANK_IRQ_ENABLE, CFG_LINE_MATCH_IRQ_ENABLE};
		val = '{tgt, hen, ven, men};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_write  <= 1'b0;
		target_q   = tgt;
		hb_irq_en  = hen[0];
		vb_irq_en  = ven[0];
		lm_irq_en  = men[0];
		reg_writes += 4;
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure plus the long hold-off on request,
	// and the in-order check of every accepted beat.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.dot_position = res_ch.dot_position;
			got.line_number  = res_ch.line_number;
			got.in_hblank    = res_ch.in_hblank;
			got.in_vblank    = res_ch.in_vblank;
			got.line_match   = res_ch.line_match;
			got.irq_request  = res_ch.irq_request;
			got.frame_done   = res_ch.frame_done;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result beat with nothing expected: dot=%0d line=%0d",
						$time, got.dot_position, got.line_number);
			end else begin
				want = pending_beats.pop_front();
				if (got.dot_position !== want.dot_position ||
					got.line_number !== want.line_number ||
					got.in_hblank !== want.in_hblank ||
					got.in_vblank !== want.in_vblank ||
					got.line_match !== want.line_match ||
					got.irq_request !== want.irq_request ||
					got.frame_done !== want.frame_done) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] beat %0d mismatch", $time, beats_seen);
						$display("  exp dot=%0d line=%0d hb=%b vb=%b lm=%b irq=%b fd=%b",
							want.dot_position, want.line_number, want.in_hblank,
							want.in_vblank, want.line_match, want.irq_request,
							want.frame_done);
						$display("  got dot=%0d line=%0d hb=%b vb=%b lm=%b irq=%b fd=%b",
							got.dot_position, got.line_number, got.in_hblank,
							got.in_vblank, got.line_match, got.irq_request,
							got.frame_done);
					end
				end
			end
			if (got.frame_done) frames_seen++;
			if (got.irq_request[IRQ_MATCH]) match_pulses++;
			if (got.irq_request[IRQ_HBLANK]) hb_pulses++;
			if (got.irq_request[IRQ_VBLANK]) vb_pulses++;
		end

		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = PRESSURE_CYCLES;
		end
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: nothing accepted on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] no beat accepted for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_beats.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.advance = 1'b0;
		res_ch.ready    = 1'b0;

		// predictor mirrors the reset state
		dot_q     = '0;
		line_q    = '0;
		hblank_q  = 1'b0;
		vblank_q  = 1'b0;
		match_q   = 1'b0;
		target_q  = '0;
		hb_irq_en = 1'b0;
		vb_irq_en = 1'b0;
		lm_irq_en = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the first two lines at full rate: target line 1,
		// enables written as 0xFF so only bit 0 may count.
		program_regs(8'd1, 8'hFF, 8'hFF, 8'hFF);
		foreach (plan[i])
			for (int unsigned k = 0; k < plan[i].reps; k++)
				send_tick(plan[i].adv, plan[i].pinned && (k == plan[i].reps - 1),
					plan[i].want);
		settle();

		// Random part: three idling profiles, four register settings each.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int c = 0; c < 4; c++) begin
				settle();
				case (c)
					0: program_regs(8'd0, 8'h00, 8'h00, 8'h00);
					// written mid-line: new target only counts from the next line
					1: program_regs(line_q + 8'd1, 8'hFF, 8'hFF, 8'hFF);
					// out-of-range target never matches
					2: program_regs(8'd255, 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
					default: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				endcase
				for (int n = 0; n < CHUNK_TICKS; n++) begin
					// back-pressure burst while the sender keeps offering
					if (ph == 2 && c == 0 && n == 20) hold_req = 1'b1;
					send_tick($urandom_range(99) < 80, 1'b0, '0);
				end
			end
		end

		settle();
		repeat (4) @(posedge clk);

		$display("Checked %0d result beats (%0d hold ticks), %0d register writes, %0d frame ends",
			beats_seen, hold_ticks, reg_writes, frames_seen);
		$display("irq pulses: vblank %0d, hblank %0d, line match %0d; %0d mismatches",
			vb_pulses, hb_pulses, match_pulses, mismatches);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
